@@ rtl/core/alfl_pkg.sv @@
// Shared constants, entry and RAM request types for the address-to-line lookup.
// No dependencies; alfl_ifs, alfl_search and the top level refer to this package by scope.
`timescale 1ns / 1ps

package alfl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    // Fixed field widths of the item and result beats
    localparam int COUNT_W     = 11;
    localparam int ENTRY_IDX_W = 10;
    localparam int RES_IDX_W   = 10;
    localparam int LINE_W      = 16;
    localparam int ADDR_W      = 32;
    localparam int ENTRY_W     = LINE_W + ADDR_W;

    // Item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic [LINE_W-1:0] line;
        logic [ADDR_W-1:0] addr;
    } t_entry;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_entry           wdata;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_PROBE,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/alfl_ifs.sv @@
// Valid/ready channel interfaces for item beats and result beats.
// Depends on alfl_pkg for field widths.
`timescale 1ns / 1ps

interface alfl_in_if;
    logic                            valid;
    logic                            ready;
    logic                            kind;
    logic [alfl_pkg::ENTRY_IDX_W-1:0] entry_index;
    logic [alfl_pkg::LINE_W-1:0]     entry_line;
    logic [alfl_pkg::ADDR_W-1:0]     entry_address;
    logic [alfl_pkg::ADDR_W-1:0]     query_address;
    logic                            exact_only;

    modport source (
        output valid, kind, entry_index, entry_line, entry_address,
               query_address, exact_only,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_line, entry_address,
               query_address, exact_only,
        output ready
    );
endinterface

interface alfl_out_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [alfl_pkg::RES_IDX_W-1:0] result_index;
    logic [alfl_pkg::LINE_W-1:0]   result_line;

    modport source (
        output valid, found, result_index, result_line,
        input  ready
    );
    modport sink (
        input  valid, found, result_index, result_line,
        output ready
    );
endinterface

@@ rtl/core/alfl_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module alfl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read in the same cycle; read data is registered and shows in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/alfl_search.sv @@
// Search sequencer: stores write beats into the table RAM and runs the
// floor search for query beats, one RAM probe per cycle, into an output register.
// Depends on alfl_pkg and alfl_ifs.
`timescale 1ns / 1ps

module alfl_search (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [alfl_pkg::COUNT_W-1:0]  i_entry_count,
    alfl_in_if.sink                       i_in,
    alfl_out_if.source                    o_out,
    output alfl_pkg::t_ram_req            o_ram_req,
    input  alfl_pkg::t_entry              i_ram_rdata
);

    alfl_pkg::t_state r_state, n_state;

    // Query context and search bounds
    logic [alfl_pkg::ADDR_W-1:0] r_q, n_q;
    logic                        r_exact, n_exact;
    logic [alfl_pkg::IDX_W-1:0]  r_lo, n_lo;
    logic [alfl_pkg::IDX_W-1:0]  r_hi, n_hi;
    logic [alfl_pkg::IDX_W-1:0]  r_mid, n_mid;
    alfl_pkg::t_entry            r_lo_ent, n_lo_ent;
    logic [alfl_pkg::IDX_W-1:0]  r_pick, n_pick;
    alfl_pkg::t_entry            r_pick_ent, n_pick_ent;
    logic                        r_hit, n_hit;

    // Result register
    logic                           r_out_valid, n_out_valid;
    logic                           r_out_found, n_out_found;
    logic [alfl_pkg::RES_IDX_W-1:0] r_out_index, n_out_index;
    logic [alfl_pkg::LINE_W-1:0]    r_out_line, n_out_line;

    logic        in_beat;
    logic        out_free;
    logic [31:0] count_sat;
    logic        count_zero;
    logic [alfl_pkg::IDX_W-1:0] last_idx;
    logic        wr_in_range;
    logic [31:0] wr_idx_wide;
    logic [31:0] pick_wide;
    logic        res_found;

    // Narrowed interval after the current probe
    logic                       rd_le;
    logic [alfl_pkg::IDX_W-1:0] c_lo, c_hi, c_span, c_mid;
    alfl_pkg::t_entry           c_lo_ent;
    logic                       c_more;

    assign in_beat  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // Saturate the entry count at the table depth
    always_comb begin
        if (32'(i_entry_count) > 32'(alfl_pkg::TABLE_DEPTH)) begin
            count_sat = 32'(alfl_pkg::TABLE_DEPTH);
        end else begin
            count_sat = 32'(i_entry_count);
        end
    end
    assign count_zero  = (count_sat == 32'd0);
    assign last_idx    = alfl_pkg::IDX_W'(count_sat - 32'd1);

    assign wr_idx_wide = 32'(i_in.entry_index);
    assign wr_in_range = wr_idx_wide < 32'(alfl_pkg::TABLE_DEPTH);

    // Compare probe data and narrow the interval
    assign rd_le = (i_ram_rdata.addr <= r_q);
    always_comb begin
        if (r_state == alfl_pkg::S_PROBE) begin
            c_lo     = rd_le ? r_mid : r_lo;
            c_hi     = rd_le ? r_hi : r_mid;
            c_lo_ent = rd_le ? i_ram_rdata : r_lo_ent;
        end else begin
            c_lo     = r_lo;
            c_hi     = r_hi;
            c_lo_ent = r_lo_ent;
        end
        c_span = c_hi - c_lo;
        c_mid  = c_lo + (c_span >> 1);
        c_more = (c_span > alfl_pkg::IDX_W'(1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            alfl_pkg::S_IDLE: begin
                if (in_beat && i_in.kind == alfl_pkg::KIND_QUERY) begin
                    n_state = count_zero ? alfl_pkg::S_DONE : alfl_pkg::S_FIRST;
                end
            end
            alfl_pkg::S_FIRST: begin
                n_state = rd_le ? alfl_pkg::S_LAST : alfl_pkg::S_DONE;
            end
            alfl_pkg::S_LAST: begin
                if (!rd_le && c_more) begin
                    n_state = alfl_pkg::S_PROBE;
                end else begin
                    n_state = alfl_pkg::S_DONE;
                end
            end
            alfl_pkg::S_PROBE: begin
                n_state = c_more ? alfl_pkg::S_PROBE : alfl_pkg::S_DONE;
            end
            alfl_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = alfl_pkg::S_IDLE;
                end
            end
            default: n_state = alfl_pkg::S_IDLE;
        endcase
    end

    // Handshake and RAM port
    always_comb begin
        i_in.ready      = 1'b0;
        o_ram_req.we    = 1'b0;
        o_ram_req.waddr = wr_idx_wide[alfl_pkg::IDX_W-1:0];
        o_ram_req.wdata = '{line: i_in.entry_line, addr: i_in.entry_address};
        o_ram_req.raddr = '0;
        unique case (r_state)
            alfl_pkg::S_IDLE: begin
                i_in.ready   = 1'b1;
                o_ram_req.we = in_beat && i_in.kind == alfl_pkg::KIND_WRITE
                               && wr_in_range;
            end
            alfl_pkg::S_FIRST: o_ram_req.raddr = r_hi;
            alfl_pkg::S_LAST,
            alfl_pkg::S_PROBE: o_ram_req.raddr = c_mid;
            alfl_pkg::S_DONE: o_ram_req.raddr = '0;
            default: o_ram_req.raddr = '0;
        endcase
    end

    // Final verdict from the chosen entry
    assign res_found = r_hit && (!r_exact || r_pick_ent.addr == r_q);
    assign pick_wide = 32'(r_pick);

    // Datapath next values
    always_comb begin
        n_q        = r_q;
        n_exact    = r_exact;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_mid      = r_mid;
        n_lo_ent   = r_lo_ent;
        n_pick     = r_pick;
        n_pick_ent = r_pick_ent;
        n_hit      = r_hit;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_found = r_out_found;
        n_out_index = r_out_index;
        n_out_line  = r_out_line;
        unique case (r_state)
            alfl_pkg::S_IDLE: begin
                if (in_beat && i_in.kind == alfl_pkg::KIND_QUERY) begin
                    n_q     = i_in.query_address;
                    n_exact = i_in.exact_only;
                    n_lo    = '0;
                    n_hi    = last_idx;
                    n_hit   = 1'b0;
                end
            end
            alfl_pkg::S_FIRST: begin
                n_lo_ent = i_ram_rdata;
            end
            alfl_pkg::S_LAST: begin
                n_mid = c_mid;
                if (rd_le) begin
                    n_pick     = r_hi;
                    n_pick_ent = i_ram_rdata;
                    n_hit      = 1'b1;
                end else if (!c_more) begin
                    n_pick     = r_lo;
                    n_pick_ent = r_lo_ent;
                    n_hit      = 1'b1;
                end
            end
            alfl_pkg::S_PROBE: begin
                n_lo     = c_lo;
                n_hi     = c_hi;
                n_lo_ent = c_lo_ent;
                n_mid    = c_mid;
                if (!c_more) begin
                    n_pick     = c_lo;
                    n_pick_ent = c_lo_ent;
                    n_hit      = 1'b1;
                end
            end
            alfl_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = res_found;
                    n_out_index = res_found ? pick_wide[alfl_pkg::RES_IDX_W-1:0] : '0;
                    n_out_line  = res_found ? r_pick_ent.line : '0;
                end
            end
            default: n_hit = 1'b0;
        endcase
    end

    // Control registers reset, payload registers do not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alfl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q         <= n_q;
        r_exact     <= n_exact;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_lo_ent    <= n_lo_ent;
        r_pick      <= n_pick;
        r_pick_ent  <= n_pick_ent;
        r_hit       <= n_hit;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
        r_out_line  <= n_out_line;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.found        = r_out_found;
    assign o_out.result_index = r_out_index;
    assign o_out.result_line  = r_out_line;

endmodule

@@ rtl/core/address_to_line_floor_lookup.sv @@
// Address-to-line floor lookup: a write beat is stored in the table RAM and gives no result.
// A query beat runs a floor search over the first n entries (n the entry count), one table
// RAM read per cycle, and gives one result beat. One item is in search at a time; the
// next beat is taken the cycle after the result registers.
// Reset (synchronous, active low) clears the entry count and control state; the
// table RAM is not cleared and holds no defined data until written.
`timescale 1ns / 1ps

module address_to_line_floor_lookup (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [alfl_pkg::COUNT_W-1:0] i_cfg_wdata,
    alfl_in_if.sink                      i_in,
    alfl_out_if.source                   o_out
);

    logic [alfl_pkg::COUNT_W-1:0] r_entry_count;
    alfl_pkg::t_ram_req           ram_req;
    logic [alfl_pkg::ENTRY_W-1:0] ram_rdata;

    // Hold the entry count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_we) begin
            r_entry_count <= i_cfg_wdata;
        end
    end

    alfl_search u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry_count (r_entry_count),
        .i_in          (i_in),
        .o_out         (o_out),
        .o_ram_req     (ram_req),
        .i_ram_rdata   (alfl_pkg::t_entry'(ram_rdata))
    );

    alfl_ram #(
        .WIDTH (alfl_pkg::ENTRY_W),
        .DEPTH (alfl_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

endmodule
